[rtl/core/knob_volume_pulse_generator_unit_macros.svh]
// Assertion helpers shared by the block.
`ifndef KNOB_VOLUME_PULSE_GENERATOR_UNIT_MACROS_SVH
`define KNOB_VOLUME_PULSE_GENERATOR_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define KVPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define KVPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/kvpg_pkg.sv]
package kvpg_pkg;

  // Queue and count sizing.
  localparam int QUEUE_DEPTH = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Saturation bounds of a queued count.
  localparam longint CountMax = (64'sd1 <<< (COUNT_WIDTH - 1)) - 64'sd1;
  localparam longint CountMin = -CountMax - 64'sd1;

  typedef logic signed [COUNT_WIDTH-1:0] count_t;

  // Pulse bit masks in the consumer report.
  localparam logic [1:0] BIT_NONE     = 2'b00;
  localparam logic [1:0] BIT_VOL_UP   = 2'b01;
  localparam logic [1:0] BIT_VOL_DOWN = 2'b10;

  typedef enum logic [1:0] {
    OP_MOTION = 2'd0,
    OP_BUILD  = 2'd1,
    OP_SENT   = 2'd2
  } op_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

[rtl/core/kvpg_fifo.sv]
module kvpg_fifo (
  input  logic               clk,
  input  logic               rst,
  input  kvpg_pkg::fifo_ctl_t ctl,
  input  kvpg_pkg::count_t   push_data,
  output kvpg_pkg::fifo_sts_t sts,
  output kvpg_pkg::count_t   head_data
);

  kvpg_pkg::count_t entries [kvpg_pkg::QUEUE_DEPTH];
  logic [kvpg_pkg::PTR_W-1:0] head;
  logic [kvpg_pkg::PTR_W-1:0] tail;
  logic [kvpg_pkg::CNT_W-1:0] fill;

  // Status flags and the oldest entry.
  assign sts.empty = (fill == '0);
  assign sts.full  = (fill == kvpg_pkg::CNT_W'(kvpg_pkg::QUEUE_DEPTH));
  assign head_data = entries[head];

  // Storage is written at the tail; it is not cleared at reset.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entries[tail] <= push_data;
    end
  end

  // Pointers wrap at the queue depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (ctl.push) begin
        tail <= (tail == kvpg_pkg::PTR_W'(kvpg_pkg::QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (ctl.pop) begin
        head <= (head == kvpg_pkg::PTR_W'(kvpg_pkg::QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
        fill <= fill + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[rtl/core/kvpg_pulse.sv]
module kvpg_pulse (
  input  logic                clk,
  input  logic                rst,
  input  logic                build_en,
  input  logic                sent_en,
  input  logic [7:0]          key_bits,
  input  kvpg_pkg::fifo_sts_t fifo_sts,
  input  kvpg_pkg::count_t    head_data,
  output logic                pop,
  output logic [7:0]          report_bits
);

  kvpg_pkg::count_t pending_steps;
  kvpg_pkg::count_t pending_steps_next;
  logic [1:0]       pulse_bit;
  logic [1:0]       pulse_bit_next;
  logic             release_pending;
  logic             release_pending_next;
  logic [7:0]       last_sent;
  logic [7:0]       last_sent_next;

  kvpg_pkg::count_t cand;
  logic             have_count;
  logic [1:0]       step_bit;
  logic [7:0]       busy_bits;
  logic             busy;

  // Pick the count to work on and the key it drives.
  always_comb begin
    have_count = 1'b0;
    cand       = pending_steps;
    if (pulse_bit == kvpg_pkg::BIT_NONE) begin
      have_count = (pending_steps != '0) || !fifo_sts.empty;
      cand       = (pending_steps != '0) ? pending_steps : head_data;
    end
    step_bit  = (cand > 0) ? kvpg_pkg::BIT_VOL_DOWN : kvpg_pkg::BIT_VOL_UP;
    busy_bits = key_bits | last_sent;
    busy      = |(busy_bits[1:0] & step_bit);
  end

  // Report build and acknowledgement handling.
  always_comb begin
    pending_steps_next   = pending_steps;
    pulse_bit_next       = pulse_bit;
    release_pending_next = release_pending;
    last_sent_next       = last_sent;
    pop                  = 1'b0;
    report_bits          = '0;

    if (build_en) begin
      report_bits = key_bits | {6'b0, pulse_bit & {2{!release_pending}}};
      if (pulse_bit == kvpg_pkg::BIT_NONE) begin
        report_bits = key_bits;
        if (have_count) begin
          pop = (pending_steps == '0);
          if (busy) begin
            pending_steps_next = cand;
          end else begin
            pulse_bit_next     = step_bit;
            pending_steps_next = (cand > 0) ? cand - kvpg_pkg::count_t'(1)
                                            : cand + kvpg_pkg::count_t'(1);
            report_bits        = key_bits | {6'b0, step_bit};
          end
        end
      end
    end

    if (sent_en) begin
      last_sent_next = key_bits;
      if (pulse_bit != kvpg_pkg::BIT_NONE) begin
        if (!release_pending && ((key_bits[1:0] & pulse_bit) != 2'b00)) begin
          release_pending_next = 1'b1;
        end else if (release_pending && ((key_bits[1:0] & pulse_bit) == 2'b00)) begin
          pulse_bit_next       = kvpg_pkg::BIT_NONE;
          release_pending_next = 1'b0;
        end
      end
    end
  end

  // Pulse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_steps   <= '0;
      pulse_bit       <= kvpg_pkg::BIT_NONE;
      release_pending <= 1'b0;
      last_sent       <= '0;
    end else begin
      pending_steps   <= pending_steps_next;
      pulse_bit       <= pulse_bit_next;
      release_pending <= release_pending_next;
      last_sent       <= last_sent_next;
    end
  end

endmodule

[rtl/core/knob_volume_pulse_generator_unit.sv]
// Throughput: one item per cycle while results are drained; the input register and
// the result register are updated together, so a held result still leaves room
// for one more beat.
// Reset clears the queue pointers, the pulse state and both valid flags.
// The queue storage itself is not cleared.
`include "knob_volume_pulse_generator_unit_macros.svh"

module knob_volume_pulse_generator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic signed [15:0] motion_amount,
  input  logic [7:0]  key_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  report_bits,
  output logic        queue_overflow
);

  logic               s1_valid;
  logic [1:0]         s1_op;
  logic signed [15:0] s1_amount;
  logic [7:0]         s1_keys;
  logic               advance;

  logic               is_motion;
  logic               is_build;
  logic               is_sent;
  logic signed [33:0] amount_ext;
  kvpg_pkg::count_t   sat_amount;
  logic               overflow;
  logic [7:0]         report;
  logic               pop;

  kvpg_pkg::fifo_ctl_t fifo_ctl;
  kvpg_pkg::fifo_sts_t fifo_sts;
  kvpg_pkg::count_t    head_data;

  // The held beat moves on when the result register is free or being drained.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op     <= operation;
      s1_amount <= motion_amount;
      s1_keys   <= key_bits;
    end
  end

  // Operation decode.
  always_comb begin
    is_motion = 1'b0;
    is_build  = 1'b0;
    is_sent   = 1'b0;
    unique case (kvpg_pkg::op_t'(s1_op))
      kvpg_pkg::OP_MOTION: is_motion = 1'b1;
      kvpg_pkg::OP_BUILD:  is_build  = 1'b1;
      kvpg_pkg::OP_SENT:   is_sent   = 1'b1;
      default: ;
    endcase
  end

  // Saturate the motion to the signed range of a queued count.
  always_comb begin
    amount_ext = 34'(s1_amount);
    if (amount_ext > 34'(kvpg_pkg::CountMax)) begin
      sat_amount = kvpg_pkg::count_t'(kvpg_pkg::CountMax);
    end else if (amount_ext < 34'(kvpg_pkg::CountMin)) begin
      sat_amount = kvpg_pkg::count_t'(kvpg_pkg::CountMin);
    end else begin
      sat_amount = kvpg_pkg::count_t'(amount_ext);
    end
  end

  // Nonzero motion is queued, or flagged when the queue is full.
  assign overflow      = is_motion && (s1_amount != '0) && fifo_sts.full;
  assign fifo_ctl.push = advance && is_motion && (s1_amount != '0) && !fifo_sts.full;
  assign fifo_ctl.pop  = advance && pop;

  kvpg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fifo_ctl),
    .push_data (sat_amount),
    .sts       (fifo_sts),
    .head_data (head_data)
  );

  kvpg_pulse u_pulse (
    .clk         (clk),
    .rst         (rst),
    .build_en    (advance && is_build),
    .sent_en     (advance && is_sent),
    .key_bits    (s1_keys),
    .fifo_sts    (fifo_sts),
    .head_data   (head_data),
    .pop         (pop),
    .report_bits (report)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      report_bits    <= report;
      queue_overflow <= overflow;
    end
  end

  // Queue control never underflows or overflows the storage.
  `KVPG_ASSERT(a_pop_not_empty, fifo_ctl.pop |-> !fifo_sts.empty, "pop from empty queue")
  `KVPG_ASSERT(a_push_not_full, fifo_ctl.push |-> !fifo_sts.full, "push into full queue")
  // A stalled beat stays in the input register.
  `KVPG_ASSERT(a_hold_stalled, s1_valid && !advance |=> s1_valid, "stalled beat lost")
  // The queue is empty in the cycle after any reset cycle.
  `KVPG_ASSERT_ALWAYS(a_reset_empty, rst |=> fifo_sts.empty, "queue not empty after reset")

endmodule
